FILE: rtl/core/dls_pkg.sv
// Shared types and constants for the dashed line splitter.
`timescale 1ns / 1ps
`default_nettype none
package dls_pkg;

  localparam int unsigned CntW = 7;
  localparam logic [CntW-1:0] MulSteps  = 7'd33;
  localparam logic [CntW-1:0] SqrtSteps = 7'd33;
  localparam logic [CntW-1:0] DivSteps  = 7'd66;
  localparam int unsigned ResultLimit = 64;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;

  localparam logic [1:0] REG_DASH = 2'd0;
  localparam logic [1:0] REG_GAP  = 2'd1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_X,
    OP_MUL_Y,
    OP_STEP_MUL,
    OP_SQRT_INIT,
    OP_STEP_SQRT,
    OP_CNT_INIT,
    OP_STEP_DIV,
    OP_SINGLE,
    OP_DASH_INIT,
    OP_PT_MUL,
    OP_PT_DIV,
    OP_PT_STORE,
    OP_NEXT
  } dls_op_e;

  typedef struct packed {
    dls_op_e    op;
    logic [1:0] status;
  } dls_cmd_t;

  typedef struct packed {
    logic done;
    logic inval;
    logic len_zero;
    logic cap_over;
    logic sel_last;
    logic last;
  } dls_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/dls_ctrl.sv
// Sequencer for the dashed line splitter.
`timescale 1ns / 1ps
`default_nettype none
module dls_ctrl
  import dls_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire dls_stat_t stat_i,
  output dls_cmd_t       cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHECK = 11'b000_0000_0010,
    S_SQX   = 11'b000_0000_0100,
    S_SQY   = 11'b000_0000_1000,
    S_SQRT  = 11'b000_0001_0000,
    S_LEN   = 11'b000_0010_0000,
    S_CNT   = 11'b000_0100_0000,
    S_LIM   = 11'b000_1000_0000,
    S_PMUL  = 11'b001_0000_0000,
    S_PCALC = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   div_phase_q, div_phase_d;

  always_comb begin
    state_d     = state_q;
    div_phase_d = div_phase_q;
    cmd_o       = '{op: OP_NONE, status: ST_OK};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.inval) begin
          cmd_o   = '{op: OP_SINGLE, status: ST_INVALID};
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_MUL_X;
          state_d  = S_SQX;
        end
      end
      S_SQX: begin
        if (!stat_i.done) begin
          cmd_o.op = OP_STEP_MUL;
        end else begin
          cmd_o.op = OP_MUL_Y;
          state_d  = S_SQY;
        end
      end
      S_SQY: begin
        if (!stat_i.done) begin
          cmd_o.op = OP_STEP_MUL;
        end else begin
          cmd_o.op = OP_SQRT_INIT;
          state_d  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!stat_i.done) begin
          cmd_o.op = OP_STEP_SQRT;
        end else begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        if (stat_i.len_zero) begin
          cmd_o   = '{op: OP_SINGLE, status: ST_OK};
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_CNT_INIT;
          state_d  = S_CNT;
        end
      end
      S_CNT: begin
        if (!stat_i.done) begin
          cmd_o.op = OP_STEP_DIV;
        end else begin
          state_d = S_LIM;
        end
      end
      S_LIM: begin
        if (stat_i.cap_over) begin
          cmd_o   = '{op: OP_SINGLE, status: ST_CAPACITY};
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_DASH_INIT;
          state_d  = S_PMUL;
        end
      end
      S_PMUL: begin
        cmd_o.op    = OP_PT_MUL;
        div_phase_d = 1'b0;
        state_d     = S_PCALC;
      end
      S_PCALC: begin
        if (!stat_i.done) begin
          cmd_o.op = div_phase_q ? OP_STEP_DIV : OP_STEP_MUL;
        end else if (!div_phase_q) begin
          cmd_o.op    = OP_PT_DIV;
          div_phase_d = 1'b1;
        end else begin
          cmd_o.op = OP_PT_STORE;
          state_d  = stat_i.sel_last ? S_OUT : S_PMUL;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.op = OP_NEXT;
            state_d  = S_PMUL;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_phase_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_phase_q <= div_phase_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dls_datapath.sv
// Datapath of the dashed line splitter: shift-add multiplier, square root, divider.
`timescale 1ns / 1ps
`default_nettype none
module dls_datapath
  import dls_pkg::*;
#(
  parameter int unsigned MAX_DASHES = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dls_cmd_t           cmd_i,
  output dls_stat_t               stat_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_addr_i,
  input  wire logic [29:0]        cfg_wdata_i,
  input  wire logic signed [31:0] start_x_i,
  input  wire logic signed [31:0] start_y_i,
  input  wire logic signed [31:0] end_x_i,
  input  wire logic signed [31:0] end_y_i,
  input  wire logic signed [31:0] line_width_i,
  input  wire logic [31:0]        line_color_i,
  input  wire logic [6:0]         free_slots_i,
  output logic signed [31:0]      seg_start_x_o,
  output logic signed [31:0]      seg_start_y_o,
  output logic signed [31:0]      seg_end_x_o,
  output logic signed [31:0]      seg_end_y_o,
  output logic signed [31:0]      out_width_o,
  output logic [31:0]             out_color_o,
  output logic [5:0]              dash_index_o,
  output logic [1:0]              status_o,
  output logic                    segment_valid_o,
  output logic                    last_o
);

  localparam int unsigned LimMax = (MAX_DASHES < ResultLimit) ? MAX_DASHES : ResultLimit;
  localparam logic [6:0] CapLim = 7'(LimMax);
  localparam logic signed [33:0] LoBound = -34'sd2147483648;
  localparam logic signed [33:0] HiBound = 34'sd2147483647;

  logic [29:0] dash_q, gap_q;
  logic [CntW-1:0] cnt_q;
  logic signed [31:0] sx_q, sy_q, w_q;
  logic [31:0] color_q;
  logic [6:0]  slots_q;
  logic        dx_neg_q, dy_neg_q, inval_q;
  logic [32:0] ax_q, ay_q;
  logic [65:0] ma_q, p_q, dv_q;
  logic [32:0] mb_q, root_q;
  logic [34:0] rem_q;
  logic [33:0] drem_q, dvsr_q;
  logic [6:0]  count_q, k_q;
  logic [34:0] d_q;
  logic [1:0]  sel_q;
  logic signed [31:0] pt_q [4];
  logic        seg_valid_q;
  logic [1:0]  status_q;

  // input checks
  logic signed [32:0] dx, dy;
  logic signed [33:0] r34, minx, maxx, miny, maxy;
  logic               bad;
  always_comb begin
    dx   = 33'(end_x_i) - 33'(start_x_i);
    dy   = 33'(end_y_i) - 33'(start_y_i);
    r34  = 34'(line_width_i >>> 1);
    minx = 34'((start_x_i < end_x_i) ? start_x_i : end_x_i);
    maxx = 34'((start_x_i > end_x_i) ? start_x_i : end_x_i);
    miny = 34'((start_y_i < end_y_i) ? start_y_i : end_y_i);
    maxy = 34'((start_y_i > end_y_i) ? start_y_i : end_y_i);
    bad  = line_width_i[31]
         || ((minx - r34) < LoBound) || ((maxx + r34) > HiBound)
         || ((miny - r34) < LoBound) || ((maxy + r34) > HiBound)
         || (dash_q == '0) || (gap_q == '0);
  end

  logic [30:0] period;
  logic [36:0] sq_rem2, sq_trial;
  logic [34:0] div_r2;
  logic        div_ge;
  logic [34:0] d_end, e_val;
  logic [6:0]  limit;
  logic [33:0] q_ext, s_ext, pt_res;
  always_comb begin
    period   = 31'(dash_q) + 31'(gap_q);
    sq_rem2  = {rem_q, p_q[65:64]};
    sq_trial = {2'b00, root_q, 2'b01};
    div_r2   = {drem_q, dv_q[65]};
    div_ge   = div_r2 >= {1'b0, dvsr_q};
    d_end    = d_q + 35'(dash_q);
    e_val    = (d_end > 35'(root_q)) ? 35'(root_q) : d_end;
    limit    = (slots_q < CapLim) ? slots_q : CapLim;
    q_ext    = {1'b0, dv_q[32:0]};
    s_ext    = 34'(sel_q[0] ? sy_q : sx_q);
    pt_res   = (sel_q[0] ? dy_neg_q : dx_neg_q) ? s_ext - q_ext : s_ext + q_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_q <= 30'(4) << FRAC_BITS;
      gap_q  <= 30'(2) << FRAC_BITS;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_DASH) dash_q <= cfg_wdata_i;
        if (cfg_addr_i == REG_GAP)  gap_q  <= cfg_wdata_i;
      end
      unique case (cmd_i.op)
        OP_MUL_X, OP_MUL_Y, OP_PT_MUL: cnt_q <= MulSteps;
        OP_SQRT_INIT:                  cnt_q <= SqrtSteps;
        OP_CNT_INIT, OP_PT_DIV:        cnt_q <= DivSteps;
        OP_STEP_MUL, OP_STEP_SQRT, OP_STEP_DIV: cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        sx_q     <= start_x_i;
        sy_q     <= start_y_i;
        w_q      <= line_width_i;
        color_q  <= line_color_i;
        slots_q  <= free_slots_i;
        dx_neg_q <= dx[32];
        dy_neg_q <= dy[32];
        ax_q     <= dx[32] ? 33'(-dx) : 33'(dx);
        ay_q     <= dy[32] ? 33'(-dy) : 33'(dy);
        inval_q  <= bad;
      end
      OP_MUL_X: begin
        ma_q <= 66'(ax_q);
        mb_q <= ax_q;
        p_q  <= '0;
      end
      OP_MUL_Y: begin
        ma_q <= 66'(ay_q);
        mb_q <= ay_q;
      end
      OP_PT_MUL: begin
        ma_q <= 66'(sel_q[0] ? ay_q : ax_q);
        mb_q <= sel_q[1] ? e_val[32:0] : d_q[32:0];
        p_q  <= '0;
      end
      OP_STEP_MUL: begin
        if (mb_q[0]) p_q <= p_q + ma_q;
        ma_q <= {ma_q[64:0], 1'b0};
        mb_q <= {1'b0, mb_q[32:1]};
      end
      OP_SQRT_INIT: begin
        rem_q  <= '0;
        root_q <= '0;
      end
      OP_STEP_SQRT: begin
        p_q <= {p_q[63:0], 2'b00};
        if (sq_rem2 >= sq_trial) begin
          rem_q  <= 35'(sq_rem2 - sq_trial);
          root_q <= {root_q[31:0], 1'b1};
        end else begin
          rem_q  <= sq_rem2[34:0];
          root_q <= {root_q[31:0], 1'b0};
        end
      end
      OP_CNT_INIT: begin
        dv_q   <= 66'(34'(root_q) + 34'(period) - 34'd1);
        dvsr_q <= 34'(period);
        drem_q <= '0;
      end
      OP_PT_DIV: begin
        dv_q   <= p_q;
        dvsr_q <= 34'(root_q);
        drem_q <= '0;
      end
      OP_STEP_DIV: begin
        drem_q <= div_ge ? 34'(div_r2 - {1'b0, dvsr_q}) : div_r2[33:0];
        dv_q   <= {dv_q[64:0], div_ge};
      end
      OP_SINGLE: begin
        seg_valid_q <= 1'b0;
        status_q    <= cmd_i.status;
      end
      OP_DASH_INIT: begin
        count_q     <= dv_q[6:0];
        k_q         <= '0;
        d_q         <= '0;
        sel_q       <= '0;
        seg_valid_q <= 1'b1;
        status_q    <= ST_OK;
      end
      OP_PT_STORE: begin
        pt_q[sel_q] <= pt_res[31:0];
        sel_q       <= sel_q + 1'b1;
      end
      OP_NEXT: begin
        k_q <= k_q + 1'b1;
        d_q <= d_q + 35'(period);
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.done     = (cnt_q == '0);
    stat_o.inval    = inval_q;
    stat_o.len_zero = (root_q == '0);
    stat_o.cap_over = dv_q[33:0] > 34'(limit);
    stat_o.sel_last = (sel_q == 2'd3);
    stat_o.last     = !seg_valid_q || ((k_q + 7'd1) == count_q);
  end

  assign seg_start_x_o   = seg_valid_q ? pt_q[0] : '0;
  assign seg_start_y_o   = seg_valid_q ? pt_q[1] : '0;
  assign seg_end_x_o     = seg_valid_q ? pt_q[2] : '0;
  assign seg_end_y_o     = seg_valid_q ? pt_q[3] : '0;
  assign out_width_o     = seg_valid_q ? w_q : '0;
  assign out_color_o     = seg_valid_q ? color_q : '0;
  assign dash_index_o    = seg_valid_q ? k_q[5:0] : '0;
  assign status_o        = status_q;
  assign segment_valid_o = seg_valid_q;
  assign last_o          = stat_o.last;

endmodule
`default_nettype wire

FILE: rtl/core/dashed_line_splitter.sv
// Top level of the dashed line splitter.
// Usage: a line word enters on the in channel (valid/ready) and leaves as one
// result word per dash on the out channel (valid/ready), last marking the
// final word; an error or a zero-length line gives one word only.
// Dash and gap lengths are written through cfg_we_i/cfg_addr_i/cfg_wdata_i
// while the block is idle, a rule on the user that the block does not
// enforce; index 0 is the dash length, 1 the gap length.
// The squares of the x and y deltas, the square root of their sum and the
// dash count come first, then four multiply-divide points per dash, all on
// one shared bit-serial multiplier and restoring divider.
// One line is worked on at a time; in_ready_o is high only when idle.
// A stalled receiver holds the current result word and all work stops.
// Reset returns the sequencer to idle and loads the default lengths.
`timescale 1ns / 1ps
`default_nettype none
module dashed_line_splitter
  import dls_pkg::*;
#(
  parameter int unsigned MAX_DASHES = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_addr_i,
  input  wire logic [29:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] start_x_i,
  input  wire logic signed [31:0] start_y_i,
  input  wire logic signed [31:0] end_x_i,
  input  wire logic signed [31:0] end_y_i,
  input  wire logic signed [31:0] line_width_i,
  input  wire logic [31:0]        line_color_i,
  input  wire logic [6:0]         free_slots_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      seg_start_x_o,
  output logic signed [31:0]      seg_start_y_o,
  output logic signed [31:0]      seg_end_x_o,
  output logic signed [31:0]      seg_end_y_o,
  output logic signed [31:0]      out_width_o,
  output logic [31:0]             out_color_o,
  output logic [5:0]              dash_index_o,
  output logic [1:0]              status_o,
  output logic                    segment_valid_o,
  output logic                    last_o
);

  dls_cmd_t  cmd;
  dls_stat_t stat;

  dls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dls_datapath #(
    .MAX_DASHES (MAX_DASHES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .line_width_i    (line_width_i),
    .line_color_i    (line_color_i),
    .free_slots_i    (free_slots_i),
    .seg_start_x_o   (seg_start_x_o),
    .seg_start_y_o   (seg_start_y_o),
    .seg_end_x_o     (seg_end_x_o),
    .seg_end_y_o     (seg_end_y_o),
    .out_width_o     (out_width_o),
    .out_color_o     (out_color_o),
    .dash_index_o    (dash_index_o),
    .status_o        (status_o),
    .segment_valid_o (segment_valid_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire
